@@ hdl/gmd_pkg.sv @@
// Shared types and constants for the gradient magnitude and direction core.
// No dependencies; the core and gmd_sqrt_cell refer to this package by scoped names.
package gmd_pkg;

    localparam int unsigned GRAD_BITS_DEF     = 13;
    localparam int unsigned MAG_FRAC_BITS_DEF = 4;

    // Quantized edge direction, folded into [0, 180) degrees.
    typedef enum logic [1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } t_dir;

    // Control that travels alongside the data through every square root cell.
    typedef struct packed {
        logic valid;
        t_dir dir;
    } t_cell_ctrl;

endpackage

@@ hdl/gmd_grad_if.sv @@
// Input channel of the core: one pixel's signed gradient pair with valid/ready.
// Depends on nothing; the width comes from the GRAD_BITS parameter.
interface gmd_grad_if #(
    parameter int unsigned GRAD_BITS = 13
);
    logic                        valid;
    logic                        ready;
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;

    modport source (output valid, output grad_x, output grad_y, input ready);
    modport sink   (input valid, input grad_x, input grad_y, output ready);
endinterface

@@ hdl/gmd_mag_if.sv @@
// Output channel of the core: gradient magnitude and direction code with valid/ready.
// Depends on nothing; the magnitude width comes from the MAG_BITS parameter.
interface gmd_mag_if #(
    parameter int unsigned MAG_BITS = 17
);
    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] grad_magnitude;
    logic [1:0]          direction_code;

    modport source (output valid, output grad_magnitude, output direction_code, input ready);
    modport sink   (input valid, input grad_magnitude, input direction_code, output ready);
endinterface

@@ hdl/gradient_magnitude_direction_core.sv @@
// Gradient magnitude and quantized direction for one pixel per transfer.
//
// Input channel i_grad carries the signed horizontal and vertical gradients
// of a pixel; output channel o_res returns floor(2^MAG_FRAC_BITS * sqrt(gx^2+gy^2))
// and a direction code (0, 45, 90 or 135 degrees) for every input transfer, in order.
// Throughput is one pixel per clock cycle unless o_res.ready stalls it. On the path
// from the input transfer to o_res.valid, three front stages take absolute values,
// form the squares and decide the direction, then a row of GRAD_BITS + MAG_FRAC_BITS
// square root cells settles one root bit each, all of them registered in turn.
// All stages move together on one enable. When the receiver holds o_res.ready low
// while a result is waiting, the whole pipeline freezes and i_grad.ready drops in the
// same cycle; empty slots are not filled while the output waits, and the result is
// held stable until taken. Synchronous reset i_rst_n clears all valid bits; no
// result is shown after reset until an input has gone through the pipeline.
// Depends on gmd_pkg, gmd_grad_if, gmd_mag_if and gmd_sqrt_cell.
module gradient_magnitude_direction_core #(
    parameter int unsigned GRAD_BITS     = gmd_pkg::GRAD_BITS_DEF,
    parameter int unsigned MAG_FRAC_BITS = gmd_pkg::MAG_FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gmd_grad_if.sink   i_grad,
    gmd_mag_if.source  o_res
);

    localparam int unsigned ROOT_BITS = GRAD_BITS + MAG_FRAC_BITS;
    localparam int unsigned RAD_W     = 2 * ROOT_BITS;
    localparam int unsigned REM_W     = ROOT_BITS + 2;
    localparam int unsigned SQ_W      = 2 * GRAD_BITS;
    localparam int unsigned S2_W      = SQ_W + 2;

    logic w_en;

    // Stage A: magnitudes and sign relation.
    logic                 r_a_valid;
    logic [GRAD_BITS-1:0] r_a_ax, r_a_ay;
    logic                 r_a_same;
    logic [GRAD_BITS-1:0] n_a_ax, n_a_ay;

    // Stage B: squares.
    logic                 r_b_valid;
    logic                 r_b_same, r_b_zero, r_b_gt, r_b_xzero;
    logic [SQ_W-1:0]      r_b_ax2, r_b_ay2, r_b_d2;
    logic [S2_W-1:0]      r_b_s2;
    logic [GRAD_BITS:0]   w_b_sum;
    logic [GRAD_BITS-1:0] w_b_diff;

    // Stage C: radicand and direction.
    gmd_pkg::t_cell_ctrl  r_c_ctrl, n_c_ctrl;
    logic [RAD_W-1:0]     r_c_rad, n_c_rad;
    logic                 r_c_xzero, r_c_yzero;
    logic [SQ_W-1:0]      w_c_sumsq;
    logic [S2_W-1:0]      w_c_two_ax2;

    gmd_pkg::t_cell_ctrl  w_ctrl [0:ROOT_BITS];
    logic [RAD_W-1:0]     w_rad  [0:ROOT_BITS];
    logic [REM_W-1:0]     w_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] w_root [0:ROOT_BITS];

    // The output stage is the last cell; everything advances when it is empty or taken.
    assign w_en         = !w_ctrl[ROOT_BITS].valid || o_res.ready;
    assign i_grad.ready = w_en;

    always_comb begin
        n_a_ax = i_grad.grad_x[GRAD_BITS-1] ? (~i_grad.grad_x + GRAD_BITS'(1)) : i_grad.grad_x;
        n_a_ay = i_grad.grad_y[GRAD_BITS-1] ? (~i_grad.grad_y + GRAD_BITS'(1)) : i_grad.grad_y;
    end

    always_comb begin
        w_b_sum  = {1'b0, r_a_ax} + {1'b0, r_a_ay};
        w_b_diff = r_a_ay - r_a_ax;
    end

    // Each square is at most 2^(2*GRAD_BITS-2), so the sum fits in SQ_W bits.
    always_comb begin
        w_c_sumsq   = r_b_ax2 + r_b_ay2;
        w_c_two_ax2 = {1'b0, r_b_ax2, 1'b0};
        n_c_rad     = RAD_W'(w_c_sumsq) << (2 * MAG_FRAC_BITS);
        n_c_ctrl.valid = r_b_valid;
        if (r_b_zero || (r_b_s2 < w_c_two_ax2)) begin
            n_c_ctrl.dir = gmd_pkg::DIR_0;
        end else if (r_b_gt && ({2'b00, r_b_d2} > w_c_two_ax2)) begin
            n_c_ctrl.dir = gmd_pkg::DIR_90;
        end else if (r_b_same) begin
            n_c_ctrl.dir = gmd_pkg::DIR_45;
        end else begin
            n_c_ctrl.dir = gmd_pkg::DIR_135;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_ctrl  <= '0;
        end else if (w_en) begin
            r_a_valid <= i_grad.valid;
            r_b_valid <= r_a_valid;
            r_c_ctrl  <= n_c_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ax    <= n_a_ax;
            r_a_ay    <= n_a_ay;
            r_a_same  <= (i_grad.grad_x[GRAD_BITS-1] == i_grad.grad_y[GRAD_BITS-1]);
            r_b_ax2   <= SQ_W'(r_a_ax) * SQ_W'(r_a_ax);
            r_b_ay2   <= SQ_W'(r_a_ay) * SQ_W'(r_a_ay);
            r_b_s2    <= S2_W'(w_b_sum) * S2_W'(w_b_sum);
            r_b_d2    <= SQ_W'(w_b_diff) * SQ_W'(w_b_diff);
            r_b_gt    <= (r_a_ay > r_a_ax);
            r_b_same  <= r_a_same;
            r_b_zero  <= (r_a_ax == '0) && (r_a_ay == '0);
            r_b_xzero <= (r_a_ax == '0);
            r_c_rad   <= n_c_rad;
            r_c_xzero <= r_b_xzero;
            r_c_yzero <= (r_b_ay2 == '0);
        end
    end

    assign w_ctrl[0] = r_c_ctrl;
    assign w_rad[0]  = r_c_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        gmd_sqrt_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    assign o_res.valid          = w_ctrl[ROOT_BITS].valid;
    assign o_res.grad_magnitude = w_root[ROOT_BITS];
    assign o_res.direction_code = w_ctrl[ROOT_BITS].dir;

    // A waiting result must stall the input side.
    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_grad.ready)
        else $error("input accepted while a result waits");

    // A zero magnitude only comes from a zero gradient, which has direction 0.
    a_zero_mag_dir : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.grad_magnitude == '0)) |->
        (o_res.direction_code == gmd_pkg::DIR_0))
        else $error("zero magnitude with nonzero direction");

    // A purely vertical gradient is binned to 90 degrees.
    a_vertical_dir : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_ctrl.valid && r_c_xzero && !r_c_yzero) |-> (r_c_ctrl.dir == gmd_pkg::DIR_90))
        else $error("vertical gradient not binned to 90 degrees");

    // A frozen pipeline keeps its output result.
    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && !$past(!i_rst_n)) |=> $stable(w_root[ROOT_BITS]))
        else $error("result changed while stalled");

endmodule

@@ hdl/gmd_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit per pass.
// Depends on gmd_pkg for the control struct carried beside the data.
module gmd_sqrt_cell #(
    parameter int unsigned ROOT_BITS = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  gmd_pkg::t_cell_ctrl        i_ctrl,
    input  logic [2*ROOT_BITS-1:0]     i_rad,
    input  logic [ROOT_BITS+1:0]       i_rem,
    input  logic [ROOT_BITS-1:0]       i_root,
    output gmd_pkg::t_cell_ctrl        o_ctrl,
    output logic [2*ROOT_BITS-1:0]     o_rad,
    output logic [ROOT_BITS+1:0]       o_rem,
    output logic [ROOT_BITS-1:0]       o_root
);

    localparam int unsigned REM_W = ROOT_BITS + 2;
    localparam int unsigned RAD_W = 2 * ROOT_BITS;

    gmd_pkg::t_cell_ctrl r_ctrl;
    logic [RAD_W-1:0]     r_rad, n_rad;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [ROOT_BITS-1:0] r_root, n_root;

    logic [REM_W-1:0] w_cand;
    logic [REM_W-1:0] w_trial;
    logic             w_fit;

    // Bring down the next two radicand bits and try the root bit as a one.
    always_comb begin
        w_cand  = {i_rem[REM_W-3:0], i_rad[RAD_W-1:RAD_W-2]};
        w_trial = {i_root, 2'b01};
        w_fit   = (w_cand >= w_trial);
        n_rem   = w_fit ? (w_cand - w_trial) : w_cand;
        n_root  = {i_root[ROOT_BITS-2:0], w_fit};
        n_rad   = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ tb/sv/gradient_magnitude_direction_core_tb.sv @@
// Self-checking testbench for gradient_magnitude_direction_core: drives gradient pairs
// with random gaps and output stalls and checks every result against a local predictor.
// Depends on gmd_pkg, gmd_grad_if, gmd_mag_if and the core itself.
`timescale 1ns / 1ps

module gradient_magnitude_direction_core_tb;

    localparam int unsigned GRAD_BITS     = gmd_pkg::GRAD_BITS_DEF;
    localparam int unsigned MAG_FRAC_BITS = gmd_pkg::MAG_FRAC_BITS_DEF;
    localparam int unsigned MAG_BITS      = GRAD_BITS + MAG_FRAC_BITS;
    localparam int unsigned LATENCY       = GRAD_BITS + MAG_FRAC_BITS + 3;
    localparam int          GRAD_MAX      = (1 << (GRAD_BITS - 1)) - 1;
    localparam int          CLK_PERIOD    = 10;
    localparam int          CYCLE_LIMIT   = 200000;

    typedef struct {
        logic [MAG_BITS-1:0] magnitude;
        gmd_pkg::t_dir       dir;
    } t_grad_result;

    logic clk = 1'b0;
    logic rst_n;

    gmd_grad_if #(.GRAD_BITS(GRAD_BITS)) grad_ch ();
    gmd_mag_if  #(.MAG_BITS(MAG_BITS))   res_ch ();

    gradient_magnitude_direction_core #(
        .GRAD_BITS    (GRAD_BITS),
        .MAG_FRAC_BITS(MAG_FRAC_BITS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_grad (grad_ch),
        .o_res  (res_ch)
    );

    t_grad_result expected_results[$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    bit           tx_no_gaps    = 1'b0;
    bit           rx_no_stalls  = 1'b0;
    int           rx_hold_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_grad_result predict_gradient_result(
        input logic [GRAD_BITS-1:0] gx,
        input logic [GRAD_BITS-1:0] gy
    );
        logic [GRAD_BITS-1:0] neg_x;
        logic [GRAD_BITS-1:0] neg_y;
        longint unsigned      ax, ay, radicand, root, trial, twice_ax2, sum, diff;
        t_grad_result         r;
        neg_x = ~gx + 1'b1;
        neg_y = ~gy + 1'b1;
        ax = gx[GRAD_BITS-1] ? neg_x : gx;
        ay = gy[GRAD_BITS-1] ? neg_y : gy;

        // Settle the root one bit at a time, from the top down.
        radicand = (ax * ax + ay * ay) << (2 * MAG_FRAC_BITS);
        root = 0;
        for (int b = MAG_BITS; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        r.magnitude = root[MAG_BITS-1:0];

        twice_ax2 = 2 * ax * ax;
        sum = ax + ay;
        diff = ay - ax;
        if ((ax == 0 && ay == 0) || sum * sum < twice_ax2) begin
            r.dir = gmd_pkg::DIR_0;
        end else if (ay > ax && diff * diff > twice_ax2) begin
            r.dir = gmd_pkg::DIR_90;
        end else if (gx[GRAD_BITS-1] == gy[GRAD_BITS-1]) begin
            r.dir = gmd_pkg::DIR_45;
        end else begin
            r.dir = gmd_pkg::DIR_135;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Input transfers queue their prediction; output transfers check against the oldest one.
    always @(posedge clk) begin
        t_grad_result want;
        if (rst_n) begin
            if (grad_ch.valid && grad_ch.ready) begin
                expected_results.push_back(predict_gradient_result(grad_ch.grad_x,
                                                                   grad_ch.grad_y));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: mag %0d dir %0d",
                                              res_ch.grad_magnitude, res_ch.direction_code));
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.grad_magnitude !== want.magnitude) begin
                        report_mismatch($sformatf("magnitude %0d, predicted %0d",
                                                  res_ch.grad_magnitude, want.magnitude));
                    end
                    if (res_ch.direction_code !== want.dir) begin
                        report_mismatch($sformatf("direction %0d, predicted %0d",
                                                  res_ch.direction_code, want.dir));
                    end
                end
            end
        end
    end

    // Result side: a random stall before each transfer, or a long hold when one is requested.
    initial begin : result_receiver
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 5);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // Valid is left high after a transfer so back-to-back items need no extra edge;
    // it is lowered only when a gap follows, or by wait_for_results.
    task automatic send_gradient(input int gx, input int gy);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            grad_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        grad_ch.valid  <= 1'b1;
        grad_ch.grad_x <= gx[GRAD_BITS-1:0];
        grad_ch.grad_y <= gy[GRAD_BITS-1:0];
        do @(posedge clk); while (!grad_ch.ready);
    endtask

    task automatic wait_for_results();
        grad_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Angles close to the bin edges, near 45 degrees and on the axes, plus the full field range and small values.
    task automatic random_gradient_pair(output int gx, output int gy);
        int ax, ay;
        case ($urandom_range(0, 9))
            3: begin
                gx = $urandom_range(0, 32) - 16;
                gy = $urandom_range(0, 32) - 16;
            end
            4: begin
                ax = $urandom_range(0, 2 * GRAD_MAX + 1) - GRAD_MAX - 1;
                gx = $urandom_range(0, 1) ? ax : 0;
                gy = (gx == 0) ? ax : 0;
            end
            5, 6: begin
                ax = $urandom_range(1, GRAD_MAX);
                ay = ax * 41421 / 100000 + $urandom_range(0, 2) - 1;
                gx = $urandom_range(0, 1) ? -ax : ax;
                gy = $urandom_range(0, 1) ? -ay : ay;
            end
            7, 8: begin
                ax = $urandom_range(1, GRAD_MAX * 100000 / 241421);
                ay = ax * 241421 / 100000 + $urandom_range(0, 2) - 1;
                gx = $urandom_range(0, 1) ? -ax : ax;
                gy = $urandom_range(0, 1) ? -ay : ay;
            end
            9: begin
                ax = $urandom_range(1, GRAD_MAX);
                ay = ax + $urandom_range(0, 2) - 1;
                gx = $urandom_range(0, 1) ? -ax : ax;
                gy = $urandom_range(0, 1) ? -ay : ay;
            end
            default: begin
                gx = $urandom_range(0, 2 * GRAD_MAX + 1) - GRAD_MAX - 1;
                gy = $urandom_range(0, 2 * GRAD_MAX + 1) - GRAD_MAX - 1;
            end
        endcase
    endtask

    task automatic test_directed_cases();
        int dx[] = '{0, 5, -5, 0, 0, GRAD_MAX, -GRAD_MAX - 1, 0, 0, GRAD_MAX,
                     -GRAD_MAX - 1, GRAD_MAX, -GRAD_MAX - 1, 12, 12, -12, 5, 5, -5,
                     3, -3, 1, 4092, -1, 1};
        int dy[] = '{0, 0, 0, 7, -7, 0, 0, -GRAD_MAX - 1, GRAD_MAX, GRAD_MAX,
                     -GRAD_MAX - 1, -GRAD_MAX - 1, GRAD_MAX, 4, 5, 5, 12, 13, 13,
                     3, 3, -1, -4092, -1, 2};
        foreach (dx[i]) begin
            send_gradient(dx[i], dy[i]);
        end
        wait_for_results();
    endtask

    // Idling modes change every hundred items, so there are stretches with none at all.
    task automatic test_random_traffic(input int count);
        int gx, gy;
        int mode;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                mode = $urandom_range(0, 3);
                tx_no_gaps   = mode[0];
                rx_no_stalls = mode[1];
            end
            random_gradient_pair(gx, gy);
            send_gradient(gx, gy);
        end
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_output_backpressure();
        int gx, gy;
        tx_no_gaps = 1'b1;
        rx_hold_cycles = 4 * LATENCY;
        for (int i = 0; i < 60; i++) begin
            random_gradient_pair(gx, gy);
            send_gradient(gx, gy);
        end
        tx_no_gaps = 1'b0;
    endtask

    // The sender pauses until the pipeline is empty, then resumes.
    task automatic test_drain_and_resume();
        test_random_traffic(40);
        wait_for_results();
        test_random_traffic(40);
    endtask

    initial begin
        rst_n          <= 1'b0;
        grad_ch.valid  <= 1'b0;
        grad_ch.grad_x <= '0;
        grad_ch.grad_y <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(700);
        test_output_backpressure();
        test_drain_and_resume();
        test_random_traffic(660);

        wait_for_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
